### src/euler_yxz_view_matrix_core_assert.svh
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix_core_assert
// assertion macros for the euler yxz view matrix core
// ----------------------------------------------------------------------------
`ifndef EULER_YXZ_VIEW_MATRIX_CORE_ASSERT_SVH
`define EULER_YXZ_VIEW_MATRIX_CORE_ASSERT_SVH

// property that holds at every clock edge outside reset
`define EYV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked from the first edge, reset included
`define EYV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/eyvm_pkg.sv
// ----------------------------------------------------------------------------
// eyvm_pkg
// types, constants and arithmetic helpers of the euler yxz view matrix core
// ----------------------------------------------------------------------------
package eyvm_pkg;

  localparam int ANGLE_WIDTH  = 16;
  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int NCELLS       = NSTEPS + 8;
  localparam int QW           = 34;
  localparam int ZW           = 34;
  localparam int PW           = COORD_WIDTH + 1;
  localparam int BW           = 16;
  localparam int DW           = BW + PW + 2;

  localparam logic signed [QW-1:0] CORDIC_GAIN = QW'(64'sh26DD3B6A);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [ANGLE_WIDTH-1:0] angle_x;
    logic signed [ANGLE_WIDTH-1:0] angle_y;
    logic signed [ANGLE_WIDTH-1:0] angle_z;
  } in_word_t;

  typedef struct packed {
    logic signed [BW-1:0] u_x;
    logic signed [BW-1:0] u_y;
    logic signed [BW-1:0] u_z;
    logic signed [BW-1:0] v_x;
    logic signed [BW-1:0] v_y;
    logic signed [BW-1:0] v_z;
    logic signed [BW-1:0] w_x;
    logic signed [BW-1:0] w_y;
    logic signed [BW-1:0] w_z;
    logic signed [COORD_WIDTH-1:0] shift_u;
    logic signed [COORD_WIDTH-1:0] shift_v;
    logic signed [COORD_WIDTH-1:0] shift_w;
  } out_word_t;

  // data handed from cell to cell; each stage uses the fields it needs
  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] pz;
    logic signed [QW-1:0] xx;
    logic signed [QW-1:0] yx;
    logic signed [ZW-1:0] zx;
    logic signed [QW-1:0] xy;
    logic signed [QW-1:0] yy;
    logic signed [ZW-1:0] zy;
    logic signed [QW-1:0] xz;
    logic signed [QW-1:0] yz;
    logic signed [ZW-1:0] zz;
    logic [2:0] flip;
    logic signed [QW-1:0] t0;
    logic signed [QW-1:0] t1;
    logic signed [QW-1:0] t2;
    logic signed [QW-1:0] t3;
    logic signed [QW-1:0] t4;
    logic signed [BW-1:0] b0;
    logic signed [BW-1:0] b1;
    logic signed [BW-1:0] b2;
    logic signed [BW-1:0] b3;
    logic signed [BW-1:0] b4;
    logic signed [BW-1:0] b5;
    logic signed [BW-1:0] b6;
    logic signed [BW-1:0] b7;
    logic signed [BW-1:0] b8;
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d2;
  } eyvm_data_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000; 1:  r = 32'h12E4051D; 2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4; 4:  r = 32'h028B0D43; 5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E; 7:  r = 32'h00517C55; 8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2E; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
      15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
      21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // q30 product rounded back to q30
  function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return QW'(p >>> 30);
  endfunction

  function automatic logic signed [BW-1:0] to_q14(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] r;
    r = (v + QW'(32768)) >>> 16;
    if (r > QW'(16384)) r = QW'(16384);
    else if (r < -QW'(16384)) r = -QW'(16384);
    return BW'(r);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_shift(
      input logic signed [DW+1:0] t);
    logic signed [DW+1:0] r;
    logic signed [DW+1:0] hi;
    logic signed [DW+1:0] lo;
    hi = (DW+2)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo = -hi - 1;
    r = (t + (DW+2)'(8192)) >>> 14;
    if (r > hi) r = hi;
    else if (r < lo) r = lo;
    return COORD_WIDTH'(r);
  endfunction

endpackage

### src/euler_yxz_view_matrix_core.sv
// pipeline: the cordic cells, then the math cells, the delay cells and the output register
// throughput: one word per cycle; the whole cell row advances when the output
// register is free or being taken
// reset: valid bits of the row and output clear; payload is not reset
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix_core
// camera view matrix from position and y-x-z euler angles, cordic cell row
// ----------------------------------------------------------------------------
`include "euler_yxz_view_matrix_core_assert.svh"
module euler_yxz_view_matrix_core import eyvm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  eyvm_data_t chain [NCELLS+1];
  logic [NCELLS-1:0] vld_r, vld_nxt;
  logic out_valid_r;
  out_word_t out_data_r;
  logic adv;
  logic last_v;
  eyvm_data_t last_d;

  function automatic void prep(input logic signed [ANGLE_WIDTH-1:0] a,
                               output logic signed [ZW-1:0] z,
                               output logic f);
    logic signed [ZW-1:0] t;
    t = ZW'(a) <<< (32 - ANGLE_WIDTH);
    f = 1'b0;
    z = t;
    if (t > (ZW'(1) <<< 30)) begin z = t - (ZW'(1) <<< 31); f = 1'b1; end
    else if (t < -(ZW'(1) <<< 30)) begin z = t + (ZW'(1) <<< 31); f = 1'b1; end
  endfunction

  always_comb begin
    chain[0] = '0;
    chain[0].px = PW'(in_data.pos_x);
    chain[0].py = -PW'(in_data.pos_y);
    chain[0].pz = PW'(in_data.pos_z);
    chain[0].xx = CORDIC_GAIN; chain[0].xy = CORDIC_GAIN; chain[0].xz = CORDIC_GAIN;
    prep(in_data.angle_x, chain[0].zx, chain[0].flip[0]);
    prep(in_data.angle_y, chain[0].zy, chain[0].flip[1]);
    prep(in_data.angle_z, chain[0].zz, chain[0].flip[2]);
  end

  assign last_v = vld_r[NCELLS-1];
  assign last_d = chain[NCELLS];
  assign adv = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  genvar g;
  generate
    for (g = 0; g < NSTEPS; g++) begin : g_cordic
      eyvm_cordic_cell u_cell (
        .clk(clk), .en(adv), .step(5'(g)), .d_in(chain[g]), .d_out(chain[g+1]));
    end
    for (g = 0; g < 6; g++) begin : g_math
      eyvm_math_cell u_cell (
        .clk(clk), .en(adv), .stage(3'(g)), .d_in(chain[NSTEPS+g]),
        .d_out(chain[NSTEPS+g+1]));
    end
    // two trailing delay cells; the fields they rotate are no longer read
    for (g = NSTEPS + 6; g < NCELLS; g++) begin : g_pass
      eyvm_cordic_cell u_cell (
        .clk(clk), .en(adv), .step(5'(TABLE_LEN)), .d_in(chain[g]), .d_out(chain[g+1]));
    end
  endgenerate

  assign vld_nxt = {vld_r[NCELLS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_nxt;
      out_valid_r <= last_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.u_x <= last_d.b0; out_data_r.u_y <= last_d.b1;
      out_data_r.u_z <= last_d.b2; out_data_r.v_x <= last_d.b3;
      out_data_r.v_y <= last_d.b4; out_data_r.v_z <= last_d.b5;
      out_data_r.w_x <= last_d.b6; out_data_r.w_y <= last_d.b7;
      out_data_r.w_z <= last_d.b8;
      out_data_r.shift_u <= sat_shift(-(DW+2)'(last_d.d0));
      out_data_r.shift_v <= sat_shift(-(DW+2)'(last_d.d1));
      out_data_r.shift_w <= sat_shift(-(DW+2)'(last_d.d2));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  `EYV_ASSERT(a_stall_holds, out_valid && out_stall |=> out_valid, "word lost under stall")
  `EYV_ASSERT(a_no_accept_stall, in_stall |-> out_valid && out_stall, "input stalled without cause")
  `EYV_ASSERT(a_row_moves, !in_stall && vld_r[NCELLS-1] |=> out_valid, "finished word dropped")

endmodule

### src/eyvm_cordic_cell.sv
// ----------------------------------------------------------------------------
// eyvm_cordic_cell
// one cordic rotation on all three angles, registered
// ----------------------------------------------------------------------------
module eyvm_cordic_cell import eyvm_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] step,
  input  eyvm_data_t d_in,
  output eyvm_data_t d_out
);

  eyvm_data_t d_r;
  eyvm_data_t d_nxt;
  logic signed [ZW-1:0] atn;

  assign atn = ZW'(atan_turn(int'(step)));

  function automatic void rot(input logic signed [QW-1:0] x,
                              input logic signed [QW-1:0] y,
                              input logic signed [ZW-1:0] z,
                              input logic [4:0] sh,
                              input logic signed [ZW-1:0] a,
                              output logic signed [QW-1:0] xo,
                              output logic signed [QW-1:0] yo,
                              output logic signed [ZW-1:0] zo);
    if (!z[ZW-1]) begin
      xo = x - (y >>> sh);
      yo = y + (x >>> sh);
      zo = z - a;
    end else begin
      xo = x + (y >>> sh);
      yo = y - (x >>> sh);
      zo = z + a;
    end
  endfunction

  always_comb begin
    d_nxt = d_in;
    rot(d_in.xx, d_in.yx, d_in.zx, step, atn, d_nxt.xx, d_nxt.yx, d_nxt.zx);
    rot(d_in.xy, d_in.yy, d_in.zy, step, atn, d_nxt.xy, d_nxt.yy, d_nxt.zy);
    rot(d_in.xz, d_in.yz, d_in.zz, step, atn, d_nxt.xz, d_nxt.yz, d_nxt.zz);
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

### src/eyvm_math_cell.sv
// ----------------------------------------------------------------------------
// eyvm_math_cell
// one product, rounding or dot product stage after the cordic row
// ----------------------------------------------------------------------------
module eyvm_math_cell import eyvm_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [2:0] stage,
  input  eyvm_data_t d_in,
  output eyvm_data_t d_out
);

  eyvm_data_t d_r;
  eyvm_data_t d_nxt;
  logic signed [QW-1:0] sx, cx, sy, cy, sz, cz;

  always_comb begin
    d_nxt = d_in;
    // after unflip: x holds cos, y holds sin
    cx = d_in.xx; sx = d_in.yx;
    cy = d_in.xy; sy = d_in.yy;
    cz = d_in.xz; sz = d_in.yz;
    case (stage)
      3'd0: begin
        if (d_in.flip[0]) begin d_nxt.xx = -d_in.xx; d_nxt.yx = -d_in.yx; end
        if (d_in.flip[1]) begin d_nxt.xy = -d_in.xy; d_nxt.yy = -d_in.yy; end
        if (d_in.flip[2]) begin d_nxt.xz = -d_in.xz; d_nxt.yz = -d_in.yz; end
      end
      3'd1: begin
        d_nxt.t0 = qmul(sy, sx);
        d_nxt.t1 = qmul(cy, sx);
        d_nxt.t2 = qmul(cz, sy);
        d_nxt.t3 = qmul(cy, cz);
        d_nxt.t4 = qmul(cy, sz);
      end
      3'd2: begin
        d_nxt.t0 = qmul(d_in.t0, sz);
        d_nxt.t1 = qmul(d_in.t1, sz);
        d_nxt.t2 = qmul(d_in.t2, sx);
        d_nxt.t3 = qmul(d_in.t3, sx);
        d_nxt.zx = ZW'(qmul(sy, sz));
        d_nxt.zy = ZW'(qmul(cz, sy));
        d_nxt.zz = ZW'(d_in.t4);
        d_nxt.b0 = to_q14(qmul(cx, sz));
        d_nxt.b4 = to_q14(qmul(cx, cz));
        d_nxt.b6 = to_q14(qmul(cx, sy));
        d_nxt.b7 = to_q14(-sx);
        d_nxt.b8 = to_q14(qmul(cy, cx));
        d_nxt.t4 = qmul(cy, cz);
      end
      3'd3: begin
        d_nxt.b1 = d_in.b0;
        d_nxt.b0 = to_q14(d_in.t4 + d_in.t0);
        d_nxt.b2 = to_q14(d_in.t1 - QW'(d_in.zy));
        d_nxt.b3 = to_q14(d_in.t2 - QW'(d_in.zz));
        d_nxt.b5 = to_q14(d_in.t3 + QW'(d_in.zx));
      end
      3'd4: begin
        d_nxt.d0 = DW'(d_in.b0) * DW'(d_in.px) + DW'(d_in.b1) * DW'(d_in.py);
        d_nxt.d1 = DW'(d_in.b3) * DW'(d_in.px) + DW'(d_in.b4) * DW'(d_in.py);
        d_nxt.d2 = DW'(d_in.b6) * DW'(d_in.px) + DW'(d_in.b7) * DW'(d_in.py);
      end
      default: begin
        d_nxt.d0 = d_in.d0 + DW'(d_in.b2) * DW'(d_in.pz);
        d_nxt.d1 = d_in.d1 + DW'(d_in.b5) * DW'(d_in.pz);
        d_nxt.d2 = d_in.d2 + DW'(d_in.b8) * DW'(d_in.pz);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule
